// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clk edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/kpdq_pkg.sv =====
// ----------------------------------------------------------------------------
// kpdq_pkg
// Shared constants and types of the keypad debounce and event queue block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kpdq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ROWS_DEF        = 6;
	localparam int COLUMNS_DEF     = 8;

	localparam int LEVEL_BITS   = 6;
	localparam int TIME_W       = 32;
	localparam int DEB_W        = 16;
	localparam int COL_FIELD_W  = 3;
	localparam int ROW_FIELD_W  = 3;
	localparam int KEY_ENTRY_W  = TIME_W + 1;
	localparam int EVENT_W      = ROW_FIELD_W + COL_FIELD_W + 1;
	localparam int TDATA_IN_W   = 48;
	localparam int TDATA_OUT_W  = 8;

	localparam logic [DEB_W-1:0] DEB_RESET = 16'd20;

	localparam logic KIND_SCAN = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// Hand-off from the key state stage to the queue
	typedef struct packed {
		logic                   valid;
		logic                   pop;
		logic [COL_FIELD_W-1:0] column;
	} req_t;

endpackage

`default_nettype wire

// ===== src/kpdq_ram.sv =====
// ----------------------------------------------------------------------------
// kpdq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kpdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/kpdq_scan.sv =====
// ----------------------------------------------------------------------------
// kpdq_scan
// Key state stage: reads one column of key state, debounces every row of it,
// writes the column back and hands the change mask to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kpdq_scan #(
	parameter int ROWS    = kpdq_pkg::ROWS_DEF,
	parameter int COLUMNS = kpdq_pkg::COLUMNS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output      logic                               in_ready,
	input  wire logic                               in_kind,
	input  wire logic [kpdq_pkg::COL_FIELD_W-1:0]   in_column,
	input  wire logic [kpdq_pkg::LEVEL_BITS-1:0]    in_levels,
	input  wire logic [kpdq_pkg::TIME_W-1:0]        in_now,
	input  wire logic [kpdq_pkg::DEB_W-1:0]         debounce_ms,
	output      kpdq_pkg::req_t                     req,
	output      logic [ROWS-1:0]                    req_mask,
	output      logic [ROWS-1:0]                    req_pressed,
	input  wire logic                               req_ready
);

	localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int XW = ($clog2(COLUMNS + 1) > kpdq_pkg::COL_FIELD_W) ?
		$clog2(COLUMNS + 1) : kpdq_pkg::COL_FIELD_W;
	localparam int EW = ROWS * kpdq_pkg::KEY_ENTRY_W;

	logic [XW-1:0] in_col_x;
	logic [CW-1:0] in_col_addr;
	logic          in_range;
	logic          in_acc;

	logic                             s1_valid_q;
	logic                             kind_s1;
	logic [kpdq_pkg::COL_FIELD_W-1:0] col_s1;
	logic [CW-1:0]                    addr_s1;
	logic                             range_s1;
	logic [kpdq_pkg::LEVEL_BITS-1:0]  lvl_s1;
	logic [kpdq_pkg::TIME_W-1:0]      now_s1;
	logic                             colv_s1;
	logic                             fwd_s1;
	logic [EW-1:0]                    fwd_data_s1;

	logic [COLUMNS-1:0] col_valid_q;
	logic [EW-1:0]      rd_data;
	logic [EW-1:0]      cur_entry;
	logic [EW-1:0]      new_entry;
	logic [ROWS-1:0]    chg_vec;
	logic [ROWS-1:0]    pressed_vec;
	logic               s1_fire;
	logic               wr_en;

	assign in_col_x    = XW'(in_column);
	assign in_col_addr = in_col_x[CW-1:0];
	assign in_range    = (in_col_x < XW'(COLUMNS));

	assign s1_fire  = s1_valid_q && req_ready;
	assign in_ready = !s1_valid_q || req_ready;
	assign in_acc   = in_valid && in_ready;
	assign wr_en    = s1_fire && (kind_s1 == kpdq_pkg::KIND_SCAN) && range_s1;

	kpdq_ram #(
		.WIDTH(EW),
		.DEPTH(COLUMNS)
	) u_key_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(new_entry),
		.re   (in_acc),
		.raddr(in_col_addr),
		.rdata(rd_data)
	);

	// Forwarded write wins over the RAM; an unwritten column reads as zero.
	assign cur_entry   = fwd_s1 ? fwd_data_s1 : (colv_s1 ? rd_data : '0);
	assign pressed_vec = ROWS'(~lvl_s1);

	always_comb begin
		logic                        stable;
		logic [kpdq_pkg::TIME_W-1:0] tm;
		logic [kpdq_pkg::TIME_W-1:0] elapsed;
		new_entry = cur_entry;
		chg_vec   = '0;
		for (int r = 0; r < ROWS; r++) begin
			stable  = cur_entry[r*kpdq_pkg::KEY_ENTRY_W + kpdq_pkg::TIME_W];
			tm      = cur_entry[r*kpdq_pkg::KEY_ENTRY_W +: kpdq_pkg::TIME_W];
			elapsed = now_s1 - tm;
			chg_vec[r] = range_s1 && (pressed_vec[r] != stable) &&
				(elapsed > kpdq_pkg::TIME_W'(debounce_ms));
			if (chg_vec[r]) begin
				new_entry[r*kpdq_pkg::KEY_ENTRY_W +: kpdq_pkg::KEY_ENTRY_W] =
					{pressed_vec[r], now_s1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			col_valid_q <= '0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (wr_en) begin
				col_valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1     <= in_kind;
			col_s1      <= in_column;
			addr_s1     <= in_col_addr;
			range_s1    <= in_range;
			lvl_s1      <= in_levels;
			now_s1      <= in_now;
			colv_s1     <= col_valid_q[in_col_addr];
			// Catch a write-back to the column being read in the same cycle
			fwd_s1      <= wr_en && (addr_s1 == in_col_addr);
			fwd_data_s1 <= new_entry;
		end
	end

	assign req.valid   = s1_valid_q;
	assign req.pop     = kind_s1;
	assign req.column  = col_s1;
	assign req_mask    = chg_vec;
	assign req_pressed = pressed_vec;

endmodule

`default_nettype wire

// ===== src/kpdq_queue.sv =====
// ----------------------------------------------------------------------------
// kpdq_queue
// Event ring queue: pushes the events of a scan one per cycle in row order,
// serves pops from the event RAM through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kpdq_queue #(
	parameter int QUEUE_DEPTH = kpdq_pkg::QUEUE_DEPTH_DEF,
	parameter int ROWS        = kpdq_pkg::ROWS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire kpdq_pkg::req_t                      req,
	input  wire logic [ROWS-1:0]                     req_mask,
	input  wire logic [ROWS-1:0]                     req_pressed,
	output      logic                                req_ready,
	output      logic                                m_tvalid,
	input  wire logic                                m_tready,
	// event_row [2:0], event_column [5:3], event_pressed [6], zero [7]
	output      logic [kpdq_pkg::TDATA_OUT_W-1:0]    m_tdata,
	// event_valid [0]
	output      logic [0:0]                          m_tuser
);

	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RXW = (RW > kpdq_pkg::ROW_FIELD_W) ? RW : kpdq_pkg::ROW_FIELD_W;

	logic [ROWS-1:0]                  mask_q;
	logic [ROWS-1:0]                  pressed_q;
	logic [kpdq_pkg::COL_FIELD_W-1:0] col_q;
	logic [PW-1:0]                    wp_q;
	logic [PW-1:0]                    rp_q;
	logic                             rd_q;
	logic                             rd_empty_q;
	logic                             m_valid_q;
	logic                             m_evalid_q;
	logic [kpdq_pkg::EVENT_W-1:0]     m_data_q;

	logic [RW-1:0]                    sel;
	logic [RXW-1:0]                   sel_x;
	logic [PW-1:0]                    wp_nxt;
	logic [PW-1:0]                    rp_nxt;
	logic                             push_active;
	logic                             full;
	logic                             empty;
	logic                             fire;
	logic                             pop_fire;
	logic                             ev_we;
	logic                             ev_re;
	logic [kpdq_pkg::EVENT_W-1:0]     ev_wdata;
	logic [kpdq_pkg::EVENT_W-1:0]     ev_rdata;

	// Lowest pending row goes first
	always_comb begin
		sel = '0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (mask_q[r]) begin
				sel = RW'(r);
			end
		end
	end

	assign sel_x       = RXW'(sel);
	assign push_active = |mask_q;
	assign wp_nxt      = (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_nxt      = (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign full        = (wp_nxt == rp_q);
	assign empty       = (wp_q == rp_q);
	assign ev_we       = push_active && !full;
	assign ev_wdata    = {pressed_q[sel], col_q, sel_x[kpdq_pkg::ROW_FIELD_W-1:0]};

	// A pop needs the pushes done and a free output slot when its data lands
	assign req_ready = !push_active &&
		((req.pop == kpdq_pkg::KIND_POP) ? (!rd_q && (!m_valid_q || m_tready)) : 1'b1);
	assign fire      = req.valid && req_ready;
	assign pop_fire  = fire && (req.pop == kpdq_pkg::KIND_POP);
	assign ev_re     = pop_fire && !empty;

	kpdq_ram #(
		.WIDTH(kpdq_pkg::EVENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_event_ram (
		.clk  (clk),
		.we   (ev_we),
		.waddr(wp_q),
		.wdata(ev_wdata),
		.re   (ev_re),
		.raddr(rp_q),
		.rdata(ev_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			wp_q      <= '0;
			rp_q      <= '0;
			rd_q      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (fire && (req.pop == kpdq_pkg::KIND_SCAN)) begin
				mask_q <= req_mask;
			end else if (push_active) begin
				mask_q <= mask_q & ~(ROWS'(1) << sel);
			end
			// Drop the event when full; the key state is already updated
			if (ev_we) begin
				wp_q <= wp_nxt;
			end
			if (ev_re) begin
				rp_q <= rp_nxt;
			end
			rd_q <= pop_fire;
			if (rd_q) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (req.pop == kpdq_pkg::KIND_SCAN)) begin
			pressed_q <= req_pressed;
			col_q     <= req.column;
		end
		if (pop_fire) begin
			rd_empty_q <= empty;
		end
		if (rd_q) begin
			m_data_q   <= rd_empty_q ? '0 : ev_rdata;
			m_evalid_q <= !rd_empty_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_data_q};
	assign m_tuser  = m_evalid_q;

endmodule

`default_nettype wire

// ===== src/keypad_matrix_debounce_event_queue.sv =====
// Path: a pop passes the key state stage register, the event RAM read and
// the output register; a scan passes the key state stage, then pushes its
// events in row order through the one event RAM write port. Throughput: 1
// scan per cycle unless pushing or a pop waits; pops wait for the last read.
// Reset: key state, pointers and debounce_ms (20) are ready at once; the
// event RAM is not cleared and is read only where written.
// ----------------------------------------------------------------------------
// keypad_matrix_debounce_event_queue
// Debounces a key matrix scanned one column at a time and queues press and
// release events for readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keypad_matrix_debounce_event_queue #(
	parameter int QUEUE_DEPTH = kpdq_pkg::QUEUE_DEPTH_DEF,
	parameter int ROWS        = kpdq_pkg::ROWS_DEF,
	parameter int COLUMNS     = kpdq_pkg::COLUMNS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [kpdq_pkg::DEB_W-1:0]         cfg_wdata,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	// column [2:0], row_levels [8:3], now_ms [40:9], zero [47:41]
	input  wire logic [kpdq_pkg::TDATA_IN_W-1:0]    s_tdata,
	// kind [0]
	input  wire logic [0:0]                         s_tuser,
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	// event_row [2:0], event_column [5:3], event_pressed [6], zero [7]
	output      logic [kpdq_pkg::TDATA_OUT_W-1:0]   m_tdata,
	// event_valid [0]
	output      logic [0:0]                         m_tuser
);

	localparam int LVL_LO = kpdq_pkg::COL_FIELD_W;
	localparam int NOW_LO = LVL_LO + kpdq_pkg::LEVEL_BITS;

	logic [kpdq_pkg::DEB_W-1:0] debounce_q;
	kpdq_pkg::req_t             req;
	logic [ROWS-1:0]            req_mask;
	logic [ROWS-1:0]            req_pressed;
	logic                       req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kpdq_pkg::DEB_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	kpdq_scan #(
		.ROWS   (ROWS),
		.COLUMNS(COLUMNS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser[0]),
		.in_column  (s_tdata[kpdq_pkg::COL_FIELD_W-1:0]),
		.in_levels  (s_tdata[LVL_LO +: kpdq_pkg::LEVEL_BITS]),
		.in_now     (s_tdata[NOW_LO +: kpdq_pkg::TIME_W]),
		.debounce_ms(debounce_q),
		.req        (req),
		.req_mask   (req_mask),
		.req_pressed(req_pressed),
		.req_ready  (req_ready)
	);

	kpdq_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ROWS       (ROWS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.req_mask   (req_mask),
		.req_pressed(req_pressed),
		.req_ready  (req_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire

// ===== src/kpdq_chk.sv =====
// ----------------------------------------------------------------------------
// kpdq_chk
// Port-level checks of the keypad event queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kpdq_chk #(
	parameter int ROWS    = kpdq_pkg::ROWS_DEF,
	parameter int COLUMNS = kpdq_pkg::COLUMNS_DEF
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [kpdq_pkg::TDATA_OUT_W-1:0] m_tdata,
	input wire logic [0:0]                       m_tuser
);

	// Hold a stalled result
	`CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// An empty-queue pop carries all-zero fields
	`CHK_IMPLY(a_empty_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "empty pop with nonzero fields")

	// Events only name keys that exist
	`CHK_IMPLY(a_row_range, m_tvalid && m_tuser[0], (ROWS > 7) || (m_tdata[2:0] < ROWS), "event row out of range")
	`CHK_IMPLY(a_col_range, m_tvalid && m_tuser[0], (COLUMNS > 7) || (m_tdata[5:3] < COLUMNS), "event column out of range")

endmodule

bind keypad_matrix_debounce_event_queue kpdq_chk #(
	.ROWS   (ROWS),
	.COLUMNS(COLUMNS)
) u_kpdq_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire
